/* design/tnps_pkg.sv */
// Shared types, codes and widths of the trajectory nearest point store.
// Used by the controller, the datapath and the top level; depends on nothing.
package tnps_pkg;

    localparam int MAX_POINTS_DEF = 256;

    localparam int POS_W   = 32;        // x and y, 1/256 m
    localparam int TIME_W  = 48;        // query or append time, ms
    localparam int PT_W    = 32;        // stored relative time, ms
    localparam int QT_W    = TIME_W + 1; // query time after base subtraction
    localparam int BASE_W  = 47;
    localparam int IDX_W   = 8;
    localparam int STS_W   = 2;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 64;
    localparam int SQ_W    = 2 * POS_W;  // one exact square
    localparam int DIST_W  = SQ_W + 1;   // sum of two squares

    // Command codes of an input item.
    localparam logic [2:0] CMD_CLEAR  = 3'd0;
    localparam logic [2:0] CMD_APPEND = 3'd1;
    localparam logic [2:0] CMD_POS    = 3'd2;
    localparam logic [2:0] CMD_REL    = 3'd3;
    localparam logic [2:0] CMD_ABS    = 3'd4;

    // Result status codes.
    localparam logic [STS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STS_W-1:0] ST_FULL  = 2'd2;

    // Register index of base_time (paddr bit 3, 8-byte registers).
    localparam logic REG_BASE_TIME = 1'b0;

    // What the datapath does with an item in the cycle of its transfer.
    typedef enum logic [2:0] {
        ACC_NONE   = 3'd0,
        ACC_CLEAR  = 3'd1,
        ACC_APPEND = 3'd2,
        ACC_NOP    = 3'd3,
        ACC_EMPTY  = 3'd4,
        ACC_POS    = 3'd5,
        ACC_REL    = 3'd6,
        ACC_ABS    = 3'd7
    } t_acc;

    typedef struct packed {
        t_acc acc;
        logic scan_rd;
        logic pick;
        logic fetch;
        logic fetch_ld;
        logic emit;
    } t_ctl;

    typedef struct packed {
        logic empty;
        logic scan_last;
        logic pipe_busy;
        logic out_free;
    } t_sts;

endpackage

/* design/tnps_ram.sv */
// Generic simple dual-port RAM with one write port and a registered read port.
// Stand-alone; no package needed.
module tnps_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/tnps_ctrl.sv */
// Controller state machine of the trajectory nearest point store.
// Depends on tnps_pkg for the command and status structs.
module tnps_ctrl import tnps_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_cmd,
    input  t_sts       i_sts,
    output logic       o_stall,
    output t_ctl       o_ctl
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_SCAN  = 7'b0000010,
        S_DRAIN = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_FETCH = 7'b0010000,
        S_LOAD  = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    always_comb begin
        n_state        = r_state;
        o_ctl          = '0;
        o_ctl.acc      = ACC_NONE;
        o_stall        = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    n_state = S_DONE;
                    case (i_cmd)
                        CMD_CLEAR:  o_ctl.acc = ACC_CLEAR;
                        CMD_APPEND: o_ctl.acc = ACC_APPEND;
                        CMD_POS: begin
                            o_ctl.acc = i_sts.empty ? ACC_EMPTY : ACC_POS;
                            n_state   = i_sts.empty ? S_DONE : S_SCAN;
                        end
                        CMD_REL: begin
                            o_ctl.acc = i_sts.empty ? ACC_EMPTY : ACC_REL;
                            n_state   = i_sts.empty ? S_DONE : S_SCAN;
                        end
                        CMD_ABS: begin
                            o_ctl.acc = i_sts.empty ? ACC_EMPTY : ACC_ABS;
                            n_state   = i_sts.empty ? S_DONE : S_SCAN;
                        end
                        default:    o_ctl.acc = ACC_NOP;
                    endcase
                end
            end
            S_SCAN: begin
                o_ctl.scan_rd = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    n_state = S_PICK;
                end
            end
            S_PICK: begin
                o_ctl.pick = 1'b1;
                n_state    = S_FETCH;
            end
            S_FETCH: begin
                o_ctl.fetch = 1'b1;
                n_state     = S_LOAD;
            end
            S_LOAD: begin
                o_ctl.fetch_ld = 1'b1;
                n_state        = S_DONE;
            end
            S_DONE: begin
                if (i_sts.out_free) begin
                    o_ctl.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

/* design/tnps_dp.sv */
// Datapath of the trajectory nearest point store: point RAM, point count,
// distance pipeline, time search, result staging and output register.
// Depends on tnps_pkg and tnps_ram.
module tnps_dp import tnps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_ctl                     i_ctl,
    output t_sts                     o_sts,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [TIME_W-1:0] i_time_value,
    input  logic [BASE_W-1:0]        i_base_time,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [STS_W-1:0]         o_status,
    output logic [IDX_W-1:0]         o_match_index,
    output logic signed [POS_W-1:0]  o_match_x,
    output logic signed [POS_W-1:0]  o_match_y,
    output logic signed [PT_W-1:0]   o_match_time
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);
    localparam int RW = 2 * POS_W + PT_W;

    // Table state.
    logic [CW-1:0] r_count;
    logic          full;
    logic          empty;
    logic          we;
    logic [RW-1:0] wdata;
    logic [AW-1:0] raddr;
    logic [RW-1:0] rdata;
    logic signed [POS_W-1:0] rd_x, rd_y;
    logic signed [PT_W-1:0]  rd_t;
    logic signed [PT_W-1:0]  sat_t;

    // Query and scan.
    logic signed [POS_W-1:0] r_qx, r_qy;
    logic signed [QT_W-1:0]  r_qt;
    logic                    r_tmode;
    logic [AW-1:0]           r_scan_addr;
    logic [AW-1:0]           r_last_idx;

    // Distance pipeline.
    logic          r_v1, r_v2, r_v3, r_v4;
    logic [AW-1:0] r_i1, r_i2, r_i3, r_i4;
    logic [POS_W-1:0]  r_ax, r_ay;
    logic [SQ_W-1:0]   r_sx, r_sy;
    logic [DIST_W-1:0] r_sum;
    logic [DIST_W-1:0] r_best_d;
    logic              r_have;
    logic [AW-1:0]     r_best_idx;
    logic signed [POS_W:0] dx, dy;

    // Time search.
    logic                   r_found;
    logic [AW-1:0]          r_low;
    logic signed [PT_W-1:0] r_t_low, r_t_prev;
    logic                   t_ge;
    logic signed [QT_W:0]   pair_sum;
    logic                   upper_closer;

    // Result staging and output register.
    logic [STS_W-1:0]       r_res_status;
    logic [IDX_W-1:0]       r_res_idx;
    logic signed [POS_W-1:0] r_res_x, r_res_y;
    logic signed [PT_W-1:0] r_res_t;
    logic                   r_o_valid;
    logic [STS_W-1:0]       r_o_status;
    logic [IDX_W-1:0]       r_o_idx;
    logic signed [POS_W-1:0] r_o_x, r_o_y;
    logic signed [PT_W-1:0] r_o_t;

    assign full  = (r_count == CW'(MAX_POINTS));
    assign empty = (r_count == '0);

    // Clamp the append time to the stored 32-bit range.
    always_comb begin
        if (i_time_value[TIME_W-1:PT_W-1] == '0 ||
            i_time_value[TIME_W-1:PT_W-1] == '1) begin
            sat_t = i_time_value[PT_W-1:0];
        end else if (i_time_value[TIME_W-1]) begin
            sat_t = {1'b1, {(PT_W-1){1'b0}}};
        end else begin
            sat_t = {1'b0, {(PT_W-1){1'b1}}};
        end
    end

    assign we    = (i_ctl.acc == ACC_APPEND) && !full;
    assign wdata = {sat_t, i_pos_y, i_pos_x};
    assign raddr = i_ctl.fetch ? r_best_idx : r_scan_addr;

    tnps_ram #(
        .WIDTH (RW),
        .DEPTH (MAX_POINTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign rd_x = rdata[POS_W-1:0];
    assign rd_y = rdata[2*POS_W-1:POS_W];
    assign rd_t = rdata[RW-1:2*POS_W];

    assign dx   = {rd_x[POS_W-1], rd_x} - {r_qx[POS_W-1], r_qx};
    assign dy   = {rd_y[POS_W-1], rd_y} - {r_qy[POS_W-1], r_qy};
    assign t_ge = ($signed({{(QT_W-PT_W){rd_t[PT_W-1]}}, rd_t}) >= r_qt);

    // Upper point wins when t_low - t < t - t_prev, that is t_low + t_prev < 2t.
    assign pair_sum     = (QT_W+1)'(r_t_low) + (QT_W+1)'(r_t_prev);
    assign upper_closer = (pair_sum < $signed({r_qt, 1'b0}));

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= '0;
            r_v1      <= 1'b0;
            r_v2      <= 1'b0;
            r_v3      <= 1'b0;
            r_v4      <= 1'b0;
            r_have    <= 1'b0;
            r_found   <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            if (i_ctl.acc == ACC_CLEAR) begin
                r_count <= '0;
            end else if (we) begin
                r_count <= r_count + CW'(1);
            end
            r_v1 <= i_ctl.scan_rd;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            if (i_ctl.acc == ACC_POS || i_ctl.acc == ACC_REL || i_ctl.acc == ACC_ABS) begin
                r_have  <= 1'b0;
                r_found <= 1'b0;
            end else begin
                if (r_v4 && !r_tmode) begin
                    r_have <= 1'b1;
                end
                if (r_v1 && r_tmode && t_ge) begin
                    r_found <= 1'b1;
                end
            end
            if (i_ctl.emit) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        case (i_ctl.acc)
            ACC_CLEAR, ACC_NOP: begin
                r_res_status <= ST_OK;
                r_res_idx    <= '0;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_t      <= '0;
            end
            ACC_EMPTY: begin
                r_res_status <= ST_EMPTY;
                r_res_idx    <= '0;
                r_res_x      <= '0;
                r_res_y      <= '0;
                r_res_t      <= '0;
            end
            ACC_APPEND: begin
                r_res_status <= full ? ST_FULL : ST_OK;
                r_res_idx    <= full ? '0 : IDX_W'(r_count);
                r_res_x      <= full ? '0 : i_pos_x;
                r_res_y      <= full ? '0 : i_pos_y;
                r_res_t      <= full ? '0 : sat_t;
            end
            ACC_POS, ACC_REL, ACC_ABS: begin
                r_qx        <= i_pos_x;
                r_qy        <= i_pos_y;
                r_tmode     <= (i_ctl.acc != ACC_POS);
                r_scan_addr <= '0;
                r_last_idx  <= AW'(r_count - CW'(1));
                if (i_ctl.acc == ACC_ABS) begin
                    r_qt <= QT_W'(i_time_value) - QT_W'(i_base_time);
                end else begin
                    r_qt <= QT_W'(i_time_value);
                end
            end
            default: begin
            end
        endcase

        if (i_ctl.scan_rd) begin
            r_scan_addr <= r_scan_addr + AW'(1);
        end

        // Stage 1: RAM data; absolute differences and the time search.
        r_i1 <= r_scan_addr;
        r_i2 <= r_i1;
        r_ax <= dx[POS_W] ? POS_W'(-dx) : dx[POS_W-1:0];
        r_ay <= dy[POS_W] ? POS_W'(-dy) : dy[POS_W-1:0];
        if (r_v1 && r_tmode && !r_found) begin
            if (t_ge) begin
                r_low   <= r_i1;
                r_t_low <= rd_t;
            end else begin
                r_t_prev <= rd_t;
            end
        end

        // Stage 2: squares.
        r_i3 <= r_i2;
        r_sx <= r_ax * r_ax;
        r_sy <= r_ay * r_ay;

        // Stage 3: sum of squares.
        r_i4  <= r_i3;
        r_sum <= {1'b0, r_sx} + {1'b0, r_sy};

        // Stage 4: keep the strictly smaller distance, so the lower index wins ties.
        if (r_v4 && !r_tmode && (!r_have || r_sum < r_best_d)) begin
            r_best_d   <= r_sum;
            r_best_idx <= r_i4;
        end

        if (i_ctl.pick && r_tmode) begin
            if (!r_found) begin
                r_best_idx <= r_last_idx;
            end else if (r_low == '0) begin
                r_best_idx <= '0;
            end else if (upper_closer) begin
                r_best_idx <= r_low;
            end else begin
                r_best_idx <= r_low - AW'(1);
            end
        end

        if (i_ctl.fetch_ld) begin
            r_res_status <= ST_OK;
            r_res_idx    <= IDX_W'(r_best_idx);
            r_res_x      <= rd_x;
            r_res_y      <= rd_y;
            r_res_t      <= rd_t;
        end

        if (i_ctl.emit) begin
            r_o_status <= r_res_status;
            r_o_idx    <= r_res_idx;
            r_o_x      <= r_res_x;
            r_o_y      <= r_res_y;
            r_o_t      <= r_res_t;
        end
    end

    assign o_sts.empty     = empty;
    assign o_sts.scan_last = (r_scan_addr == r_last_idx);
    assign o_sts.pipe_busy = r_v1 | r_v2 | r_v3 | r_v4;
    assign o_sts.out_free  = !r_o_valid || !i_stall;

    assign o_valid       = r_o_valid;
    assign o_status      = r_o_status;
    assign o_match_index = r_o_idx;
    assign o_match_x     = r_o_x;
    assign o_match_y     = r_o_y;
    assign o_match_time  = r_o_t;

endmodule

/* design/trajectory_nearest_point_store.sv */
// Trajectory nearest point store. Clear, append and every query on an empty
// table need no scan; a position or time query on N points reads the point
// RAM once per point, then drains, picks and fetches the winner. Items are
// handled one at a time; a finished result may wait in the output register
// while the next item is taken. Synchronous active-low reset empties the
// table and clears base_time; the point RAM itself is not cleared.
module trajectory_nearest_point_store import tnps_pkg::*; #(
    parameter int MAX_POINTS = MAX_POINTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // Item input channel.
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [2:0]               i_cmd,
    input  logic signed [POS_W-1:0]  i_pos_x,
    input  logic signed [POS_W-1:0]  i_pos_y,
    input  logic signed [TIME_W-1:0] i_time_value,
    // Result output channel.
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [STS_W-1:0]         o_status,
    output logic [IDX_W-1:0]         o_match_index,
    output logic signed [POS_W-1:0]  o_match_x,
    output logic signed [POS_W-1:0]  o_match_y,
    output logic signed [PT_W-1:0]   o_match_time,
    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [PADDR_W-1:0]       paddr,
    input  logic [PDATA_W-1:0]       pwdata,
    output logic [PDATA_W-1:0]       prdata,
    output logic                     pready
);

    // The single register, base_time, sits at byte address 0 and is 8 bytes
    // wide, so bit 3 of the address selects the register and the low bits
    // only address bytes inside it.
    logic [BASE_W-1:0] r_base_time;
    logic              cfg_wr;

    t_ctl ctl;
    t_sts sts;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;
    assign prdata = (paddr[3] == REG_BASE_TIME) ? PDATA_W'(r_base_time) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_time <= '0;
        end else if (cfg_wr && paddr[3] == REG_BASE_TIME) begin
            r_base_time <= pwdata[BASE_W-1:0];
        end
    end

    // The controller takes an item only in its idle state and steers the
    // datapath through the scan, the final choice and the fetch of the winner.
    tnps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_cmd   (i_cmd),
        .i_sts   (sts),
        .o_stall (o_stall),
        .o_ctl   (ctl)
    );

    // The datapath holds the points in one RAM row of x, y and time, runs
    // every scanned point through a four-stage distance pipeline and a time
    // comparison, and keeps the result in an output register.
    tnps_dp #(
        .MAX_POINTS (MAX_POINTS)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (ctl),
        .o_sts         (sts),
        .i_pos_x       (i_pos_x),
        .i_pos_y       (i_pos_y),
        .i_time_value  (i_time_value),
        .i_base_time   (r_base_time),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_match_index (o_match_index),
        .o_match_x     (o_match_x),
        .o_match_y     (o_match_y),
        .o_match_time  (o_match_time)
    );

    // After an input transfer the block is busy with that item.
    a_busy_after_transfer: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall
    ) else $error("input taken again right after a transfer");

    // A result with an error status carries no point.
    a_error_result_zero: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |->
            (o_match_index == '0 && o_match_x == '0 && o_match_y == '0 &&
             o_match_time == '0)
    ) else $error("error result carries point data");

    // The table is never scanned while it holds no point.
    a_scan_nonempty: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        ctl.scan_rd |-> !sts.empty
    ) else $error("scan of an empty table");

endmodule

/* sim/trajectory_nearest_point_store_tb.sv */
// Testbench of the trajectory nearest point store: a directed table, then random
// clear/append/query sequences, every result checked against a typed or in-bench model answer.
// Depends on tnps_pkg and the trajectory_nearest_point_store top level.
module trajectory_nearest_point_store_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tnps_pkg::*;

    localparam int NPTS        = MAX_POINTS_DEF;
    localparam int ITEM_TARGET = 1900;
    localparam int DIR_ROWS    = 24;

    // Command codes that the block has no use for; it answers them with an all-zero result.
    localparam logic [2:0] CMD_SPARE5 = 3'd5;
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    // base_time is wider than 32 bits, so registers sit 8 bytes apart.
    localparam logic [PADDR_W-1:0] BASE_TIME_ADDR = PADDR_W'(8 * int'(REG_BASE_TIME));

    localparam logic signed [POS_W-1:0]  POS_MIN = 32'sh8000_0000;
    localparam logic signed [POS_W-1:0]  POS_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [PT_W-1:0]   PT_MIN  = 32'sh8000_0000;
    localparam logic signed [PT_W-1:0]   PT_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [TIME_W-1:0] T48_MIN = 48'sh8000_0000_0000;
    localparam logic signed [TIME_W-1:0] T48_MAX = 48'sh7FFF_FFFF_FFFF;
    localparam logic [BASE_W-1:0]        BASE_MAX = {BASE_W{1'b1}};
    localparam longint                   PT_HI = 64'sd2147483647;
    localparam longint                   PT_LO = -64'sd2147483648;

    typedef struct packed {
        logic [STS_W-1:0]        status;
        logic [IDX_W-1:0]        index;
        logic signed [POS_W-1:0] x;
        logic signed [POS_W-1:0] y;
        logic signed [PT_W-1:0]  tm;
    } t_answer;

    // One row of the directed table. Where typed is set, want is the answer typed
    // in by hand; otherwise the lookup model supplies it.
    typedef struct packed {
        logic [2:0]               cmd;
        logic signed [POS_W-1:0]  x;
        logic signed [POS_W-1:0]  y;
        logic signed [TIME_W-1:0] tv;
        logic                     typed;
        t_answer                  want;
    } t_dir_row;

    localparam t_answer ZERO_ANS  = '0;
    localparam t_answer EMPTY_ANS = '{ST_EMPTY, 8'd0, 32'sd0, 32'sd0, 32'sd0};

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_valid;
    logic                     o_stall;
    logic [2:0]               i_cmd;
    logic signed [POS_W-1:0]  i_pos_x;
    logic signed [POS_W-1:0]  i_pos_y;
    logic signed [TIME_W-1:0] i_time_value;
    logic                     o_valid;
    logic                     i_stall;
    logic [STS_W-1:0]         o_status;
    logic [IDX_W-1:0]         o_match_index;
    logic signed [POS_W-1:0]  o_match_x;
    logic signed [POS_W-1:0]  o_match_y;
    logic signed [PT_W-1:0]   o_match_time;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [PADDR_W-1:0]       paddr;
    logic [PDATA_W-1:0]       pwdata;
    logic [PDATA_W-1:0]       prdata;
    logic                     pready;

    trajectory_nearest_point_store #(.MAX_POINTS(NPTS)) dut (.*);

    // The directed part: empty-table queries, the spare command codes, appends
    // at the field extremes (the extreme times saturate to 32 bits), a table whose
    // times are out of order, the 65-bit distance, and ties in distance and time.
    t_dir_row dir_rows [DIR_ROWS] = '{
        '{CMD_POS,    32'sd0,  32'sd0,  48'sd0,  1'b1, EMPTY_ANS},
        '{CMD_REL,    POS_MAX, POS_MIN, T48_MAX, 1'b1, EMPTY_ANS},
        '{CMD_ABS,    POS_MIN, POS_MAX, T48_MIN, 1'b1, EMPTY_ANS},
        '{CMD_SPARE5, POS_MAX, POS_MAX, T48_MAX, 1'b1, ZERO_ANS},
        '{CMD_SPARE6, POS_MIN, POS_MIN, T48_MIN, 1'b1, ZERO_ANS},
        '{CMD_SPARE7, 32'sd7,  -32'sd7, -48'sd1, 1'b1, ZERO_ANS},
        '{CMD_CLEAR,  POS_MAX, POS_MAX, T48_MAX, 1'b1, ZERO_ANS},
        '{CMD_APPEND, POS_MIN, POS_MAX, T48_MIN, 1'b1, '{ST_OK, 8'd0, POS_MIN, POS_MAX, PT_MIN}},
        '{CMD_APPEND, POS_MAX, POS_MIN, T48_MAX, 1'b1, '{ST_OK, 8'd1, POS_MAX, POS_MIN, PT_MAX}},
        '{CMD_APPEND, 32'sd0,  32'sd0,  48'sd0,  1'b1, '{ST_OK, 8'd2, 32'sd0, 32'sd0, 32'sd0}},
        '{CMD_APPEND, POS_MAX, POS_MAX, -48'sd1, 1'b1, '{ST_OK, 8'd3, POS_MAX, POS_MAX, -32'sd1}},
        '{CMD_POS,    POS_MIN, POS_MIN, 48'sd0,  1'b0, ZERO_ANS},
        '{CMD_POS,    POS_MAX, 32'sd0,  48'sd0,  1'b0, ZERO_ANS},
        '{CMD_REL,    32'sd0,  32'sd0,  T48_MIN, 1'b0, ZERO_ANS},
        '{CMD_REL,    32'sd0,  32'sd0,  T48_MAX, 1'b0, ZERO_ANS},
        '{CMD_REL,    32'sd0,  32'sd0,  48'sd0,  1'b0, ZERO_ANS},
        '{CMD_ABS,    32'sd0,  32'sd0,  T48_MAX, 1'b0, ZERO_ANS},
        '{CMD_CLEAR,  32'sd0,  32'sd0,  48'sd0,  1'b1, ZERO_ANS},
        '{CMD_APPEND, -32'sd5, 32'sd0,  48'sd10, 1'b1, '{ST_OK, 8'd0, -32'sd5, 32'sd0, 32'sd10}},
        '{CMD_APPEND, 32'sd5,  32'sd0,  48'sd20, 1'b1, '{ST_OK, 8'd1, 32'sd5, 32'sd0, 32'sd20}},
        '{CMD_POS,    32'sd0,  32'sd0,  48'sd0,  1'b0, ZERO_ANS},
        '{CMD_REL,    32'sd0,  32'sd0,  48'sd15, 1'b0, ZERO_ANS},
        '{CMD_REL,    32'sd0,  32'sd0,  48'sd16, 1'b0, ZERO_ANS},
        '{CMD_ABS,    32'sd0,  32'sd0,  T48_MIN, 1'b0, ZERO_ANS}
    };

    // Our own copy of the point table and of the register.
    logic signed [POS_W-1:0] tab_x [NPTS];
    logic signed [POS_W-1:0] tab_y [NPTS];
    logic signed [PT_W-1:0]  tab_t [NPTS];
    int                      tab_count;
    logic [BASE_W-1:0]       base_ms;

    // Answers still owed by the block, oldest first.
    t_answer answer_q [$];

    int  mismatches, results_seen, items_sent;
    int  n_clear, n_append, n_full, n_pos, n_rel, n_abs, n_empty, n_spare, n_cfg, n_fill;
    bit  calm;                  // when set, the sender puts no gaps between transfers
    longint walk_x, walk_y, walk_t;

    // ------------------------------------------------------------------
    // Lookup model
    // ------------------------------------------------------------------

    // Exact squared distance from stored point i; the sum needs one bit more
    // than a single square.
    function automatic logic [DIST_W-1:0] sq_dist(int i, logic signed [POS_W-1:0] qx,
                                                  logic signed [POS_W-1:0] qy);
        longint         dx, dy;
        logic [SQ_W-1:0] ax, ay;
        dx = longint'(tab_x[i]) - longint'(qx);
        dy = longint'(tab_y[i]) - longint'(qy);
        ax = (dx < 0) ? SQ_W'(-dx) : SQ_W'(dx);
        ay = (dy < 0) ? SQ_W'(-dy) : SQ_W'(dy);
        return DIST_W'(ax * ax) + DIST_W'(ay * ay);
    endfunction

    // Lower bound on time, then the closer of it and its predecessor; the
    // earlier point wins a tie, and the search clamps to both ends.
    function automatic int time_pick(longint qt);
        int low, i;
        low = tab_count;
        for (i = 0; i < tab_count; i++) begin
            if (longint'(tab_t[i]) >= qt) begin
                low = i;
                break;
            end
        end
        if (low == 0)
            return 0;
        if (low == tab_count)
            return tab_count - 1;
        if (longint'(tab_t[low]) - qt < qt - longint'(tab_t[low-1]))
            return low;
        return low - 1;
    endfunction

    function automatic t_answer point_answer(int i);
        t_answer a;
        a.status = ST_OK;
        a.index  = IDX_W'(i);
        a.x      = tab_x[i];
        a.y      = tab_y[i];
        a.tm     = tab_t[i];
        return a;
    endfunction

    // Applies one item to the model table and returns the answer it causes.
    function automatic t_answer lookup_answer(logic [2:0] cmd, logic signed [POS_W-1:0] x,
                                              logic signed [POS_W-1:0] y,
                                              logic signed [TIME_W-1:0] tv);
        t_answer            a;
        longint             qt;
        int                 best, i;
        logic [DIST_W-1:0]  d, best_d;
        a  = '0;
        qt = longint'(tv);
        case (cmd)
            CMD_CLEAR: tab_count = 0;
            CMD_APPEND: begin
                if (tab_count >= NPTS) begin
                    a.status = ST_FULL;
                end else begin
                    if (qt > PT_HI)
                        qt = PT_HI;
                    if (qt < PT_LO)
                        qt = PT_LO;
                    tab_x[tab_count] = x;
                    tab_y[tab_count] = y;
                    tab_t[tab_count] = PT_W'(qt);
                    a = point_answer(tab_count);
                    tab_count++;
                end
            end
            CMD_POS, CMD_REL, CMD_ABS: begin
                if (tab_count == 0) begin
                    a.status = ST_EMPTY;
                end else if (cmd == CMD_POS) begin
                    best   = 0;
                    best_d = sq_dist(0, x, y);
                    for (i = 1; i < tab_count; i++) begin
                        d = sq_dist(i, x, y);
                        if (d < best_d) begin
                            best_d = d;
                            best   = i;
                        end
                    end
                    a = point_answer(best);
                end else begin
                    if (cmd == CMD_ABS)
                        qt = qt - longint'(base_ms);
                    a = point_answer(time_pick(qt));
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    // ------------------------------------------------------------------
    // Clock, reset, checking
    // ------------------------------------------------------------------

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A long fixed limit: even if every transfer took a full-table scan plus
    // the longest gap and stall, the run would end far sooner than this.
    initial begin
        #40_000_000;
        $display("Timeout with %0d answers still owed by the block", answer_q.size());
        $display("Simulation FAILED");
        $finish;
    end

    function automatic void flag_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result %0d, %s: expected %0h, got %0h",
                         results_seen, name, want, got);
        end
    endfunction

    // Results are sampled at the clock edge, before the block's own updates
    // at that edge take effect, so the check sees the values of the transfer.
    always @(posedge i_clk) begin
        t_answer got, want;
        if (i_rst_n && o_valid === 1'b1 && i_stall === 1'b0) begin
            results_seen++;
            got.status = o_status;
            got.index  = o_match_index;
            got.x      = o_match_x;
            got.y      = o_match_y;
            got.tm     = o_match_time;
            if (answer_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: result %0d arrived with no answer owed", results_seen);
            end else begin
                want = answer_q.pop_front();
                flag_field("status", 64'(want.status), 64'(got.status));
                flag_field("match_index", 64'(want.index), 64'(got.index));
                flag_field("match_x", 64'(want.x), 64'(got.x));
                flag_field("match_y", 64'(want.y), 64'(got.y));
                flag_field("match_time", 64'(want.tm), 64'(got.tm));
            end
        end
    end

    // Mostly short gaps, a few long ones, and now and then a quiet stretch.
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 70);
    endfunction

    // Result side back-pressure. Every pass of the loop waits on the clock, so it never spins.
    initial begin
        int run, hold;
        forever begin
            run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 300) : $urandom_range(1, 8);
            i_stall <= 1'b0;
            repeat (run) @(posedge i_clk);
            hold = pause_len();
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Item channel and configuration port
    // ------------------------------------------------------------------

    // Drives one item and holds it until the transfer; the answer is worked out
    // at the edge of the transfer. Valid stays high into the next item unless
    // a gap is drawn, so it is assigned at most once per clock edge.
    task automatic send_item(logic [2:0] cmd, logic signed [POS_W-1:0] x,
                             logic signed [POS_W-1:0] y, logic signed [TIME_W-1:0] tv,
                             logic typed, t_answer want);
        int      gap;
        t_answer a;
        gap = calm ? 0 : pause_len();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_cmd        <= cmd;
        i_pos_x      <= x;
        i_pos_y      <= y;
        i_time_value <= tv;
        do @(posedge i_clk); while (o_stall !== 1'b0);
        a = lookup_answer(cmd, x, y, tv);
        answer_q.insert(answer_q.size(), typed ? want : a);
        case (cmd)
            CMD_CLEAR:  n_clear++;
            CMD_APPEND: n_append++;
            CMD_POS:    n_pos++;
            CMD_REL:    n_rel++;
            CMD_ABS:    n_abs++;
            default:    n_spare++;
        endcase
        if (cmd <= CMD_ABS)
            items_sent++;
        if (a.status == ST_FULL)
            n_full++;
        if (a.status == ST_EMPTY)
            n_empty++;
    endtask

    task automatic send(logic [2:0] cmd, logic signed [POS_W-1:0] x,
                        logic signed [POS_W-1:0] y, logic signed [TIME_W-1:0] tv);
        send_item(cmd, x, y, tv, 1'b0, ZERO_ANS);
    endtask

    // Stops sending and waits until every owed answer has come back.
    task automatic drain();
        i_valid <= 1'b0;
        while (answer_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // One register access: a setup cycle, then an access cycle that completes
    // at the edge where pready is seen high. Read data is taken at that edge.
    task automatic reg_access(logic wr, logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= BASE_TIME_ADDR;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata   = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Register writes happen only with the block idle; the read-back must
    // return what was written.
    task automatic set_base_time(logic [BASE_W-1:0] v);
        logic [PDATA_W-1:0] rd;
        drain();
        reg_access(1'b1, PDATA_W'(v), rd);
        base_ms = v;
        reg_access(1'b0, '0, rd);
        flag_field("base_time read-back", PDATA_W'(v), rd);
        n_cfg++;
    endtask

    // ------------------------------------------------------------------
    // Random stimulus
    // ------------------------------------------------------------------

    function automatic logic signed [POS_W-1:0] any_pos();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return POS_MIN;
        if (r == 1)
            return POS_MAX;
        if (r <= 5)
            return $urandom;
        return int'($urandom_range(0, 4000)) - 2000;
    endfunction

    function automatic logic signed [TIME_W-1:0] any_time48();
        int          r;
        logic [63:0] raw;
        r   = $urandom_range(0, 9);
        raw = {$urandom, $urandom};
        if (r == 0)
            return T48_MIN;
        if (r == 1)
            return T48_MAX;
        if (r <= 3)
            return TIME_W'(int'($urandom_range(0, 20000)) - 10000);
        return raw[TIME_W-1:0];
    endfunction

    // Appends points along a random walk with non-decreasing times. Repeated
    // points and equal times show up on purpose, to exercise the tie rules.
    task automatic append_walk(int n);
        int k;
        for (k = 0; k < n; k++) begin
            if ($urandom_range(0, 7) != 0) begin
                walk_x += int'($urandom_range(0, 1200)) - 600;
                walk_y += int'($urandom_range(0, 1200)) - 600;
            end
            walk_t += ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1000000)
                                                    : $urandom_range(0, 40);
            send(CMD_APPEND, POS_W'(walk_x), POS_W'(walk_y), TIME_W'(walk_t));
        end
    endtask

    // Queries aimed at the stored points: exact hits, near misses, midpoints
    // between points (ties), beyond the ends, and plain random values.
    task automatic random_query();
        int         k, j, r;
        logic [2:0] cmd;
        longint     qx, qy, qt;
        bit         raw_time;
        r        = $urandom_range(0, 9);
        cmd      = (r < 4) ? CMD_POS : (r < 7) ? CMD_REL : CMD_ABS;
        raw_time = 1'b0;
        qx       = any_pos();
        qy       = any_pos();
        qt       = any_time48();
        if (tab_count > 0) begin
            k = $urandom_range(0, tab_count - 1);
            j = $urandom_range(0, tab_count - 1);
            r = $urandom_range(0, 9);
            if (cmd == CMD_POS) begin
                if (r < 3) begin
                    qx = tab_x[k];
                    qy = tab_y[k];
                end else if (r < 6) begin
                    qx = longint'(tab_x[k]) + int'($urandom_range(0, 600)) - 300;
                    qy = longint'(tab_y[k]) + int'($urandom_range(0, 600)) - 300;
                end else if (r < 8) begin
                    qx = (longint'(tab_x[k]) + longint'(tab_x[j])) >>> 1;
                    qy = (longint'(tab_y[k]) + longint'(tab_y[j])) >>> 1;
                end
            end else begin
                if (r < 3)
                    qt = tab_t[k];
                else if (r < 5)
                    qt = longint'(tab_t[k]) + (($urandom_range(0, 1) == 0) ? -1 : 1);
                else if (r < 7 && k + 1 < tab_count)
                    qt = (longint'(tab_t[k]) + longint'(tab_t[k+1])) >>> 1;
                else if (r < 7)
                    qt = tab_t[k];
                else if (r == 7)
                    qt = longint'(tab_t[0]) - $urandom_range(0, 5000);
                else if (r == 8)
                    qt = longint'(tab_t[tab_count-1]) + $urandom_range(0, 5000);
                else
                    raw_time = 1'b1;
                if (cmd == CMD_ABS && !raw_time)
                    qt = qt + longint'(base_ms);
            end
        end
        send(cmd, POS_W'(qx), POS_W'(qy), TIME_W'(qt));
    endtask

    // Any command code with any field values.
    task automatic noise_item();
        send(3'($urandom_range(0, 7)), any_pos(), any_pos(), any_time48());
    endtask

    task automatic start_walk();
        walk_x = any_pos();
        walk_y = any_pos();
        walk_t = int'($urandom_range(0, 20000)) - 10000;
    endtask

    // Fills the table to the last entry, tries to append past it, then queries
    // the full table; each position query here scans all entries.
    task automatic fill_table();
        int k;
        n_fill++;
        start_walk();
        send(CMD_CLEAR, any_pos(), any_pos(), any_time48());
        append_walk(NPTS);
        for (k = 0; k < 3; k++)
            send(CMD_APPEND, any_pos(), any_pos(), any_time48());
        for (k = 0; k < 6; k++)
            random_query();
    endtask

    // A well-formed sequence: clear, a short run of appends, then queries with
    // the odd extra append or stray item mixed in.
    task automatic track_phase();
        int k, n, r, q;
        start_walk();
        send(CMD_CLEAR, any_pos(), any_pos(), any_time48());
        r = $urandom_range(0, 99);
        n = (r < 10) ? 0 : (r < 80) ? $urandom_range(1, 12) : $urandom_range(13, 48);
        append_walk(n);
        q = $urandom_range(3, 10);
        for (k = 0; k < q; k++) begin
            r = $urandom_range(0, 19);
            if (r < 2)
                append_walk(1);
            else if (r == 2)
                noise_item();
            else
                random_query();
        end
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        int              phase, k, r;
        logic [BASE_W-1:0] next_base;
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_cmd        <= CMD_CLEAR;
        i_pos_x      <= '0;
        i_pos_y      <= '0;
        i_time_value <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= BASE_TIME_ADDR;
        pwdata       <= '0;
        tab_count    = 0;
        base_ms      = '0;
        calm         = 1'b0;
        walk_x       = 0;
        walk_y       = 0;
        walk_t       = 0;
        for (k = 0; k < NPTS; k++) begin
            tab_x[k] = '0;
            tab_y[k] = '0;
            tab_t[k] = '0;
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        // Directed part, with base_time still at its reset value of zero.
        for (k = 0; k < DIR_ROWS; k++)
            send_item(dir_rows[k].cmd, dir_rows[k].x, dir_rows[k].y, dir_rows[k].tv,
                      dir_rows[k].typed, dir_rows[k].want);

        // Random part. Each register change waits for the block to go idle,
        // which also makes the sender hold off until all answers are in.
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            phase++;
            calm = ($urandom_range(0, 4) == 0);
            if (phase % 8 == 1) begin
                case (n_cfg % 4)
                    0: next_base = BASE_MAX;
                    1: next_base = '0;
                    2: next_base = BASE_W'({$urandom, $urandom});
                    default: next_base = BASE_W'($urandom_range(0, 100000));
                endcase
                set_base_time(next_base);
            end
            r = $urandom_range(0, 9);
            if (phase == 3 || phase == 40)
                fill_table();
            else if (r == 0)
                for (k = $urandom_range(5, 15); k > 0; k--)
                    noise_item();
            else
                track_phase();
        end

        drain();
        repeat (NPTS + 20) @(posedge i_clk);

        $display("Covered %0d items: %0d clear, %0d append (%0d full), %0d spare, %0d fills",
                 items_sent, n_clear, n_append, n_full, n_spare, n_fill);
        $display("Queries %0d pos, %0d rel, %0d abs (%0d on empty); %0d base_time writes",
                 n_pos, n_rel, n_abs, n_empty, n_cfg);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
